/* design/kms_pkg.sv */
// kms_pkg: shared types and constants of the keypad matrix scanner
// no dependencies; used by key_matrix_scanner and kms_event_merge
package kms_pkg;

  // default matrix size
  localparam int KmsRows    = 8;
  localparam int KmsColumns = 10;

  // fixed field widths
  localparam int DriveW    = 10;
  localparam int ColumnW   = 4;
  localparam int EventRowW = 3;
  localparam int LevelsW   = 8;
  localparam int IntervalW = 16;
  localparam int SettleW   = 8;
  localparam int CfgDataW  = 16;

  // register reset values
  localparam logic [IntervalW-1:0] ScanIntervalReset = 16'd20;
  localparam logic [SettleW-1:0]   SettleTicksReset  = 8'd2;

  // configuration register indexes
  typedef enum logic [0:0] {
    CfgScanInterval = 1'b0,
    CfgSettleTicks  = 1'b1
  } cfg_reg_e;

  // per tick record that goes with the row masks to the merge stage
  typedef struct packed {
    logic [DriveW-1:0]  drive;
    logic [ColumnW-1:0] column;
  } tick_rec_t;

endpackage

/* design/kms_row_lane.sv */
// kms_row_lane: one row of the sampled column, compares level with stored key bit
// no dependencies; instantiated once per row by key_matrix_scanner
module kms_row_lane (
  input  logic sample_i,
  input  logic level_i,
  input  logic stored_i,
  output logic changed_o,
  output logic next_o
);

  assign changed_o = sample_i & (level_i ^ stored_i);
  assign next_o    = sample_i ? level_i : stored_i;

endmodule

/* design/kms_event_merge.sv */
// kms_event_merge: collects the lane change flags of a tick and emits events in row order
// depends on kms_pkg
module kms_event_merge #(
  parameter int ROWS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_valid_i,
  output logic                        push_ready_o,
  input  kms_pkg::tick_rec_t          push_rec_i,
  input  logic [ROWS-1:0]             push_changed_i,
  input  logic [ROWS-1:0]             push_levels_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [kms_pkg::DriveW-1:0]  column_drive_o,
  output logic                        event_valid_o,
  output logic [kms_pkg::EventRowW-1:0] event_row_o,
  output logic [kms_pkg::ColumnW-1:0] event_column_o,
  output logic                        event_pressed_o,
  output logic                        last_of_tick_o
);
  import kms_pkg::*;

  localparam int RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // holding slot
  logic            hold_valid_q, hold_valid_d;
  tick_rec_t       hold_rec_q;
  logic [ROWS-1:0] hold_changed_q, hold_levels_q;

  // active slot, being emitted
  logic            act_valid_q, act_valid_d;
  tick_rec_t       act_rec_q;
  logic [ROWS-1:0] act_rem_q, act_levels_q;

  logic [ROWS-1:0]    rem_next;
  logic [RowIdxW-1:0] low_idx;
  logic               is_last, out_acc, act_free, push_acc, any_event;

  always_comb begin
    low_idx = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (act_rem_q[r]) begin
        low_idx = RowIdxW'(r);
      end
    end
  end

  assign rem_next  = act_rem_q & (act_rem_q - ROWS'(1));
  assign any_event = |act_rem_q;
  assign is_last   = (rem_next == '0);
  assign out_acc   = act_valid_q && out_ready_i;
  assign act_free  = !act_valid_q || (out_acc && is_last);
  assign push_ready_o = !hold_valid_q || act_free;
  assign push_acc     = push_valid_i && push_ready_o;

  assign hold_valid_d = push_acc || (hold_valid_q && !act_free);
  assign act_valid_d  = act_free ? hold_valid_q : act_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      act_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      act_valid_q  <= act_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      hold_rec_q     <= push_rec_i;
      hold_changed_q <= push_changed_i;
      hold_levels_q  <= push_levels_i;
    end
    if (act_free) begin
      act_rec_q    <= hold_rec_q;
      act_rem_q    <= hold_changed_q;
      act_levels_q <= hold_levels_q;
    end else if (out_acc) begin
      act_rem_q <= rem_next;
    end
  end

  assign out_valid_o     = act_valid_q;
  assign column_drive_o  = act_rec_q.drive;
  assign event_valid_o   = any_event;
  assign event_row_o     = any_event ? EventRowW'(low_idx) : '0;
  assign event_column_o  = any_event ? act_rec_q.column : '0;
  assign event_pressed_o = any_event & act_levels_q[low_idx];
  assign last_of_tick_o  = is_last;

endmodule

/* design/key_matrix_scanner.sv */
// key_matrix_scanner: tick driven keypad matrix scanner, top level
// depends on kms_pkg, kms_row_lane, kms_event_merge
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  row_levels_i
//   out      output     out_valid_o/out_ready_i column_drive_o, event_*_o, last_of_tick_o
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// a tick request updates the scan state in the cycle it is accepted; its results
// pass the holding and then the active slot of the merge stage and leave it one
// per cycle while out_ready_i is high; the merge stage sends a tick's events out
// serially, one per changed key, up to ROWS (8 by default)
// back to back ticks are taken while the previous tick's events still drain
// reset clears the key map, counters and scan state at once, no clearing pass
// a stalled output holds the results; input is stalled only when both slots are full
module key_matrix_scanner #(
  parameter int ROWS    = kms_pkg::KmsRows,
  parameter int COLUMNS = kms_pkg::KmsColumns
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick requests
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [kms_pkg::LevelsW-1:0]     row_levels_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kms_pkg::DriveW-1:0]      column_drive_o,
  output logic                            event_valid_o,
  output logic [kms_pkg::EventRowW-1:0]   event_row_o,
  output logic [kms_pkg::ColumnW-1:0]     event_column_o,
  output logic                            event_pressed_o,
  output logic                            last_of_tick_o,
  // register writes
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [kms_pkg::CfgDataW-1:0]    cfg_data_i
);
  import kms_pkg::*;

  localparam int ColIdxW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [ColumnW:0] NumCols = (ColumnW + 1)'(COLUMNS);
  localparam logic [ColumnW:0] LastCol = (ColumnW + 1)'(COLUMNS - 1);

  // configuration registers
  logic [IntervalW-1:0] scan_interval_q;
  logic [SettleW-1:0]   settle_ticks_q;

  // scan state
  logic [IntervalW-1:0] ticks_q, ticks_d;
  logic                 scanning_q, scanning_d;
  logic [ColumnW-1:0]   column_q, column_d;
  logic [SettleW-1:0]   settle_q, settle_d;
  logic [ROWS-1:0]      key_map_q [COLUMNS];

  logic                 in_acc, push_ready;
  logic [IntervalW-1:0] ticks_inc;
  logic                 start, active, col_in_range, sample;
  logic [ColumnW-1:0]   col_eff;
  logic [SettleW-1:0]   settle_eff;
  logic [DriveW-1:0]    drive;
  logic [ROWS-1:0]      stored, levels, changed, next_bits;
  tick_rec_t            rec;

  assign in_ready_o = push_ready;
  assign in_acc     = in_valid_i && push_ready;

  // register port, one write per enabled edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_interval_q <= ScanIntervalReset;
      settle_ticks_q  <= SettleTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgScanInterval: scan_interval_q <= cfg_data_i;
        CfgSettleTicks:  settle_ticks_q  <= cfg_data_i[SettleW-1:0];
        default: ;
      endcase
    end
  end

  // interval counter saturates, a scan starts once it passes the interval
  assign ticks_inc  = (ticks_q == '1) ? ticks_q : ticks_q + IntervalW'(1);
  assign start      = !scanning_q && (ticks_inc > scan_interval_q);
  assign active     = scanning_q || start;
  assign col_eff    = start ? '0 : column_q;
  assign settle_eff = start ? '0 : settle_q;
  assign col_in_range = ({1'b0, col_eff} < NumCols);
  assign sample     = active && col_in_range && (settle_eff >= settle_ticks_q);
  // drive bits above the port width fall off the shift
  assign drive      = (active && col_in_range) ? (DriveW'(1) << col_eff) : '0;

  always_comb begin
    ticks_d    = start ? '0 : ticks_inc;
    scanning_d = scanning_q;
    column_d   = column_q;
    settle_d   = settle_q;
    if (active) begin
      scanning_d = 1'b1;
      column_d   = col_eff;
      settle_d   = settle_eff;
      if (!col_in_range) begin
        // stale column past the matrix: drop back to idle
        scanning_d = 1'b0;
        column_d   = '0;
        settle_d   = '0;
      end else if (sample) begin
        settle_d = '0;
        if ({1'b0, col_eff} == LastCol) begin
          scanning_d = 1'b0;
          column_d   = '0;
        end else begin
          column_d = col_eff + ColumnW'(1);
        end
      end else begin
        settle_d = settle_eff + SettleW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q    <= '0;
      scanning_q <= 1'b0;
      column_q   <= '0;
      settle_q   <= '0;
    end else if (in_acc) begin
      ticks_q    <= ticks_d;
      scanning_q <= scanning_d;
      column_q   <= column_d;
      settle_q   <= settle_d;
    end
  end

  // stored keys of the column being sampled
  assign stored = col_in_range ? key_map_q[col_eff[ColIdxW-1:0]] : '0;

  // rows beyond the sampled lines read low
  always_comb begin
    levels = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (r < LevelsW) begin
        levels[r] = row_levels_i[r];
      end
    end
  end

  // one compare lane per row
  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    kms_row_lane u_lane (
      .sample_i  (sample),
      .level_i   (levels[r]),
      .stored_i  (stored[r]),
      .changed_o (changed[r]),
      .next_o    (next_bits[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLUMNS; c++) begin
        key_map_q[c] <= '0;
      end
    end else if (in_acc && sample) begin
      key_map_q[col_eff[ColIdxW-1:0]] <= next_bits;
    end
  end

  assign rec.drive  = drive;
  assign rec.column = col_eff;

  // merge stage serializes the changed rows into events
  kms_event_merge #(
    .ROWS (ROWS)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_valid_i    (in_valid_i),
    .push_ready_o    (push_ready),
    .push_rec_i      (rec),
    .push_changed_i  (changed),
    .push_levels_i   (levels),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .column_drive_o  (column_drive_o),
    .event_valid_o   (event_valid_o),
    .event_row_o     (event_row_o),
    .event_column_o  (event_column_o),
    .event_pressed_o (event_pressed_o),
    .last_of_tick_o  (last_of_tick_o)
  );

endmodule
